// ===== rtl/s512_pkg.sv =====
`timescale 1ns / 1ps

package s512_pkg;

    // One 64-bit word and the eight working or chaining words, a first.
    typedef logic [63:0]      t_word;
    typedef logic [7:0][63:0] t_hash;

    localparam int unsigned RoundCount  = 80;
    localparam int unsigned BlockWords  = 16;
    localparam int unsigned LengthWords = 14;

    // Right rotation by a fixed amount.
    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // Initial hash words; element 0 is the first word.
    function automatic t_hash init_hash();
        t_hash h;
        h[0] = 64'h6a09e667f3bcc908;
        h[1] = 64'hbb67ae8584caa73b;
        h[2] = 64'h3c6ef372fe94f82b;
        h[3] = 64'ha54ff53a5f1d36f1;
        h[4] = 64'h510e527fade682d1;
        h[5] = 64'h9b05688c2b3e6c1f;
        h[6] = 64'h1f83d9abfb41bd6b;
        h[7] = 64'h5be0cd19137e2179;
        return h;
    endfunction

    // Round constants.
    function automatic t_word round_k(input logic [6:0] idx);
        t_word k;
        case (idx)
            7'd0:  k = 64'h428a2f98d728ae22;
            7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;
            7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;
            7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;
            7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;
            7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;
            7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;
            7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;
            7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;
            7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;
            7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;
            7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;
            7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;
            7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;
            7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;
            7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;
            7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;
            7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;
            7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;
            7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;
            7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;
            7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;
            7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;
            7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;
            7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;
            7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;
            7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;
            7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;
            7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;
            7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;
            7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;
            7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;
            7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;
            7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;
            7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;
            7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;
            7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;
            7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;
            7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;
            7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;
            7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'd0;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/s512_round.sv =====
`timescale 1ns / 1ps

// One compression round and one step of the message schedule.
module s512_round
    import s512_pkg::*;
(
    input  t_hash i_v,
    input  t_word i_w0,
    input  t_word i_w1,
    input  t_word i_w9,
    input  t_word i_w14,
    input  t_word i_k,
    output t_hash o_v,
    output t_word o_w
);

    t_word sum1;
    t_word sum0;
    t_word choose;
    t_word majority;
    t_word t1;
    t_word t2;
    t_word sig0;
    t_word sig1;

    // Round function on the working words.
    always_comb begin
        sum1     = rotr(i_v[4], 14) ^ rotr(i_v[4], 18) ^ rotr(i_v[4], 41);
        choose   = (i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]);
        t1       = i_v[7] + sum1 + choose + i_k + i_w0;
        sum0     = rotr(i_v[0], 28) ^ rotr(i_v[0], 34) ^ rotr(i_v[0], 39);
        majority = (i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]);
        t2       = sum0 + majority;
        o_v[7]   = i_v[6];
        o_v[6]   = i_v[5];
        o_v[5]   = i_v[4];
        o_v[4]   = i_v[3] + t1;
        o_v[3]   = i_v[2];
        o_v[2]   = i_v[1];
        o_v[1]   = i_v[0];
        o_v[0]   = t1 + t2;
    end

    // Next schedule word, sixteen places ahead of the one in use.
    always_comb begin
        sig0 = rotr(i_w1, 1) ^ rotr(i_w1, 8) ^ (i_w1 >> 7);
        sig1 = rotr(i_w14, 19) ^ rotr(i_w14, 61) ^ (i_w14 >> 6);
        o_w  = sig1 + i_w9 + sig0 + i_w0;
    end

endmodule

// ===== rtl/sha512_hash_engine.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// message   in         i_valid / o_ready   i_message_data, i_valid_bytes, i_end_of_message
// digest    out        o_valid / i_ready   o_digest_word, o_word_number, o_final_word
//
// A message word is taken on each handshake; the sixteenth word of a block starts the 80 rounds
// on the single shared round unit, followed by folding into the chaining value.
// A last word adds the padding steps and one or two compressions before the
// eight digest words, which then go out one per transfer as fast as i_ready allows.
// The block takes no message word while it compresses, pads or emits the digest.
// Synchronous active-low reset loads the initial hash and clears all counters.
module sha512_hash_engine
    import s512_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_message_data,
    input  logic [3:0]  i_valid_bytes,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_word_number,
    output logic        o_final_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FOLD,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_NONE,
        PH_MARK,
        PH_ALIGN,
        PH_ZERO,
        PH_HI,
        PH_LO,
        PH_DONE
    } t_phase;

    t_state             r_state;
    t_phase             r_phase;
    t_hash              r_h;
    t_hash              r_v;
    logic [15:0][63:0]  r_w;
    logic [63:0]        r_acc;
    logic [2:0]         r_fill;
    logic [4:0]         r_wc;
    logic [6:0]         r_round;
    logic [63:0]        r_total;
    logic [2:0]         r_out_idx;

    logic               app_en;
    logic [63:0]        app_data;
    logic [3:0]         app_cnt;
    logic [63:0]        masked;
    logic [127:0]       merged;
    logic [3:0]         sum;
    logic               push;
    logic               full;
    logic [3:0]         in_cnt;
    logic               in_xfer;
    logic               out_xfer;
    t_hash              round_v;
    t_word              round_w;

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_h[0];
    assign o_word_number = r_out_idx;
    assign o_final_word  = (r_out_idx == 3'd7);
    assign in_xfer       = i_valid && o_ready;
    assign out_xfer      = o_valid && i_ready;
    assign in_cnt        = (i_valid_bytes > 4'd8) ? 4'd8 : i_valid_bytes;

    // Source of the bytes appended this cycle: the message word or padding.
    always_comb begin
        app_en   = 1'b0;
        app_data = 64'd0;
        app_cnt  = 4'd0;
        case (r_state)
            S_IDLE: begin
                app_en   = in_xfer;
                app_data = i_message_data;
                app_cnt  = in_cnt;
            end
            S_PAD: begin
                case (r_phase)
                    PH_MARK: begin
                        app_en   = 1'b1;
                        app_data = {8'h80, 56'd0};
                        app_cnt  = 4'd1;
                    end
                    PH_ALIGN: begin
                        app_en  = 1'b1;
                        app_cnt = {1'b0, 3'(3'd0 - r_fill)};
                    end
                    PH_ZERO: begin
                        app_en  = (r_wc != 5'(LengthWords));
                        app_cnt = 4'd8;
                    end
                    PH_HI: begin
                        app_en   = 1'b1;
                        app_data = {61'd0, r_total[63:61]};
                        app_cnt  = 4'd8;
                    end
                    PH_LO: begin
                        app_en   = 1'b1;
                        app_data = {r_total[60:0], 3'd0};
                        app_cnt  = 4'd8;
                    end
                    default: begin
                        app_en = 1'b0;
                    end
                endcase
            end
            default: begin
                app_en = 1'b0;
            end
        endcase
    end

    // Byte aligner: the held partial word and the new bytes merge into up to 15 bytes.
    always_comb begin
        masked = app_data & ~(64'hFFFF_FFFF_FFFF_FFFF >> {app_cnt, 3'b000});
        merged = {r_acc, 64'd0} | ({masked, 64'd0} >> {r_fill, 3'b000});
        sum    = {1'b0, r_fill} + app_cnt;
        push   = app_en && sum[3];
        full   = push && (r_wc == 5'(BlockWords - 1));
    end

    s512_round u_round (
        .i_v   (r_v),
        .i_w0  (r_w[0]),
        .i_w1  (r_w[1]),
        .i_w9  (r_w[9]),
        .i_w14 (r_w[14]),
        .i_k   (round_k(r_round)),
        .o_v   (round_v),
        .o_w   (round_w)
    );

    // Sequencer, message window, chaining value and digest output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_NONE;
            r_h       <= init_hash();
            r_acc     <= 64'd0;
            r_fill    <= 3'd0;
            r_wc      <= 5'd0;
            r_round   <= 7'd0;
            r_total   <= 64'd0;
            r_out_idx <= 3'd0;
        end else begin
            // Common append path.
            if (app_en) begin
                r_fill <= sum[2:0];
                r_acc  <= push ? merged[63:0] : merged[127:64];
                if (push) begin
                    r_w  <= {merged[127:64], r_w[15:1]};
                    r_wc <= r_wc + 5'd1;
                end
            end
            if (full) begin
                r_v     <= r_h;
                r_round <= 7'd0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_total <= r_total + {60'd0, in_cnt};
                        r_phase <= i_end_of_message ? PH_MARK : PH_NONE;
                        if (full) begin
                            r_state <= S_ROUND;
                        end else if (i_end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    case (r_phase)
                        PH_MARK:  r_phase <= PH_ALIGN;
                        PH_ALIGN: r_phase <= PH_ZERO;
                        PH_ZERO: begin
                            if (r_wc == 5'(LengthWords)) begin
                                r_phase <= PH_HI;
                            end
                        end
                        PH_HI:    r_phase <= PH_LO;
                        PH_LO:    r_phase <= PH_DONE;
                        default:  r_phase <= PH_DONE;
                    endcase
                    if (full) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_v     <= round_v;
                    r_w     <= {round_w, r_w[15:1]};
                    r_round <= r_round + 7'd1;
                    if (r_round == 7'(RoundCount - 1)) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_wc <= 5'd0;
                    case (r_phase)
                        PH_NONE: r_state <= S_IDLE;
                        PH_DONE: r_state <= S_OUT;
                        default: r_state <= S_PAD;
                    endcase
                end
                S_OUT: begin
                    if (out_xfer) begin
                        r_out_idx <= r_out_idx + 3'd1;
                        if (r_out_idx == 3'd7) begin
                            r_h     <= init_hash();
                            r_state <= S_IDLE;
                            r_phase <= PH_NONE;
                            r_total <= 64'd0;
                            r_acc   <= 64'd0;
                            r_fill  <= 3'd0;
                        end else begin
                            r_h <= {r_h[0], r_h[7:1]};
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // The round unit only runs on a complete block of sixteen words.
    a_round_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROUND |-> r_wc == 5'(BlockWords))
        else $error("compression running on an incomplete block");

    // Bytes of the partial word beyond the fill count are always clear.
    a_acc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc & (64'hFFFF_FFFF_FFFF_FFFF >> {r_fill, 3'b000})) == 64'd0)
        else $error("stale bytes in the partial word");

    // After the last digest word the engine is ready for a new message.
    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_final_word |=> o_ready && !o_valid && r_fill == 3'd0)
        else $error("engine not back to idle after the digest");

    // The digest only starts once the length words have been compressed.
    a_out_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_word_number == 3'd0 && r_wc == 5'd0)
        else $error("digest started out of order");
`endif

endmodule
